// ----- rtl/tss_pkg.sv -----
// Shared types, codes and defaults for the task scheduler table.
// No dependencies; the design files that use it refer to it by scoped names, the bench files import it.
`default_nettype none
package tss_pkg;

	localparam int         NUM_SLOTS_DEF = 64;
	localparam logic [5:0] IDLE_SLOT_RST = 6'd0;
	localparam logic [9:0] TICK_MS_RST   = 10'd10;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_ILLEGAL = 2'd2;

	typedef enum logic [0:0] {
		CFG_IDLE_SLOT = 1'b0,
		CFG_TICK_MS   = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_FREE     = 3'd0,
		ST_READY    = 3'd1,
		ST_RUNNING  = 3'd2,
		ST_BLOCKED  = 3'd3,
		ST_SLEEPING = 3'd4,
		ST_WAITING  = 3'd5
	} slot_st_t;

	typedef enum logic [2:0] {
		ACT_CREATE  = 3'd0,
		ACT_SCHED   = 3'd1,
		ACT_BLOCK   = 3'd2,
		ACT_UNBLOCK = 3'd3,
		ACT_SLEEP   = 3'd4,
		ACT_TICK    = 3'd5,
		ACT_ACCOUNT = 3'd6
	} act_t;

	typedef enum logic [1:0] {
		RA_IDX,
		RA_SID,
		RA_CUR,
		RA_BEST
	} ra_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CREATE,
		WR_TARGET,
		WR_SLEEP,
		WR_RETIRE,
		WR_RUN,
		WR_ACCOUNT
	} wr_op_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  slot_id;
		logic [5:0]  current_slot;
		logic        block_kind;
		logic [7:0]  prio_value;
		logic [31:0] duration_ms;
		logic [31:0] slice_value;
		logic [31:0] stamp_value;
	} req_t;

	typedef struct packed {
		logic [5:0] next_slot;
		logic       rescheduled;
		logic       switch_needed;
		logic [5:0] new_slot;
		logic [1:0] status_code;
	} rsp_t;

	typedef struct packed {
		logic       load;
		ra_sel_t    ra_sel;
		logic       scan_rd;
		logic       idx_clr;
		logic       idx_inc;
		logic       eval_sched;
		logic       eval_tick;
		logic       best_clr;
		logic       best_resolve;
		wr_op_t     wr;
		logic       div_start;
		logic       now_inc;
		logic       set_st;
		logic [1:0] st_code;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       idx_last;
		logic       slot_free;
		logic       legal;
		logic       acct_legal;
		logic       sid_is_cur;
		logic       div_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/tss_req_if.sv -----
// Request channel of the task scheduler table: valid, ready and one item.
// Depends on nothing.
`default_nettype none
interface tss_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [5:0]  slot_id;
	logic [5:0]  current_slot;
	logic        block_kind;
	logic [7:0]  prio_value;
	logic [31:0] duration_ms;
	logic [31:0] slice_value;
	logic [31:0] stamp_value;

	modport source (output valid, action, slot_id, current_slot, block_kind, prio_value,
		duration_ms, slice_value, stamp_value, input ready);
	modport sink (input valid, action, slot_id, current_slot, block_kind, prio_value,
		duration_ms, slice_value, stamp_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/tss_rsp_if.sv -----
// Response channel of the task scheduler table: valid, ready and one result.
// Depends on nothing.
`default_nettype none
interface tss_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] next_slot;
	logic       rescheduled;
	logic       switch_needed;
	logic [5:0] new_slot;
	logic [1:0] status_code;

	modport source (output valid, next_slot, rescheduled, switch_needed, new_slot,
		status_code, input ready);
	modport sink (input valid, next_slot, rescheduled, switch_needed, new_slot,
		status_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/task_scheduler_table_top.sv -----
// Task scheduler table: slot table with create, schedule, block, sleep, tick, account.
// Top level; depends on tss_pkg, tss_req_if, tss_rsp_if, tss_ctrl and tss_datapath.
//
// Usage:
//   req: one beat per item (valid/ready). rsp: exactly one result beat per item.
//   cfg_we/cfg_idx/cfg_data write idle_slot (index 0) or tick_ms (index 1);
//   write only while no item is in flight.
// Work per item, N = NUM_SLOTS, from acceptance to the result register:
//   create scans for the first free slot; account and action 7 go straight
//   to the result; unblock and any block or sleep that does not reschedule
//   check the target slot; schedule scans all N slots; block of the current
//   slot checks and then schedules; tick scans all N slots; sleep divides
//   and then schedules. One item is worked on at a time: a new item is
//   accepted only once the last has left for the result register.
// Reset: all slots free, tick clock zero, idle_slot 0, tick_ms 10; no clearing pass.
// A stalled rsp holds its beat; the next item is still accepted and worked on, and
//   waits at its end until the result register is free.
`default_nettype none
module task_scheduler_table_top #(
	parameter int NUM_SLOTS = tss_pkg::NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tss_req_if.sink    req,
	tss_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [0:0] cfg_idx,
	input  logic [9:0] cfg_data
);
	tss_pkg::dp_cmd_t  cmd;
	tss_pkg::dp_stat_t stat;
	tss_pkg::req_t     req_item;
	tss_pkg::rsp_t     rsp_item;

	assign req_item.action       = req.action;
	assign req_item.slot_id      = req.slot_id;
	assign req_item.current_slot = req.current_slot;
	assign req_item.block_kind   = req.block_kind;
	assign req_item.prio_value   = req.prio_value;
	assign req_item.duration_ms  = req.duration_ms;
	assign req_item.slice_value  = req.slice_value;
	assign req_item.stamp_value  = req.stamp_value;

	tss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.cmd(cmd), .stat(stat)
	);

	tss_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .req_item(req_item),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .rsp_item(rsp_item)
	);

	assign rsp.next_slot     = rsp_item.next_slot;
	assign rsp.rescheduled   = rsp_item.rescheduled;
	assign rsp.switch_needed = rsp_item.switch_needed;
	assign rsp.new_slot      = rsp_item.new_slot;
	assign rsp.status_code   = rsp_item.status_code;
endmodule
`default_nettype wire

// ----- rtl/tss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/tss_div.sv -----
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 10-bit divisor.
// A zero divisor is taken as one. No dependencies.
`default_nettype none
module tss_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [9:0]  divisor,
	output logic        done,
	output logic [31:0] quot
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [9:0]  rem_q;
	logic [9:0]  dvs_q;
	logic [31:0] quo_q;
	logic [10:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q, quo_q[31]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= (divisor == 10'd0) ? 10'd1 : divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 10'(rem_sh - {1'b0, dvs_q}) : rem_sh[9:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

// ----- rtl/tss_datapath.sv -----
// Datapath of the task scheduler table: slot memories, scan counter, best-candidate
// tracking, tick clock, config registers and result registers.
// Depends on tss_pkg, tss_ram and tss_div.
`default_nettype none
module tss_datapath #(
	parameter int NUM_SLOTS = tss_pkg::NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tss_pkg::dp_cmd_t  cmd,
	output tss_pkg::dp_stat_t stat,
	input  tss_pkg::req_t     req_item,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_idx,
	input  logic [9:0]        cfg_data,
	output tss_pkg::rsp_t     rsp_item
);
	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int XW = (AW > 6) ? AW : 6;
	localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

	tss_pkg::req_t    item_q;
	tss_pkg::rsp_t    res_q;
	tss_pkg::rsp_t    out_q;
	logic [5:0]       idle_q;
	logic [9:0]       tickms_q;
	logic [31:0]      now_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    idx_s1;
	logic             vld_s1;
	logic             vbit_s1;
	logic [XW-1:0]    best_q;
	logic             found_q;
	logic [31:0]      best_tk_q;
	logic [31:0]      best_sp_q;

	logic [XW-1:0]    cur_x;
	logic [XW-1:0]    sid_x;
	logic [XW-1:0]    idx_x;
	logic [XW-1:0]    idx1_x;
	logic [AW-1:0]    cur_a;
	logic [AW-1:0]    sid_a;
	logic [AW-1:0]    best_a;
	logic             cur_in;
	logic             sid_in;
	logic             best_in;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    waddr;

	logic [2:0]       st_rdata;
	logic [31:0]      tk_rdata;
	logic [31:0]      sp_rdata;
	logic [7:0]       pr_rdata;
	tss_pkg::slot_st_t st_eff;
	logic             st_we;
	logic             tk_we;
	logic             sp_we;
	logic             pr_we;
	tss_pkg::slot_st_t st_wd;
	logic [31:0]      tk_wd;
	logic [31:0]      sp_wd;
	logic             div_done;
	logic [31:0]      quot;
	logic [31:0]      sleep_t;
	logic             run_ok;
	logic             better;
	logic             legal;

	assign cur_x  = XW'(item_q.current_slot);
	assign sid_x  = XW'(item_q.slot_id);
	assign idx_x  = XW'(idx_q);
	assign idx1_x = XW'(idx_s1);
	assign cur_a  = cur_x[AW-1:0];
	assign sid_a  = sid_x[AW-1:0];
	assign best_a = best_q[AW-1:0];
	assign cur_in  = 32'(item_q.current_slot) < 32'(NUM_SLOTS);
	assign sid_in  = 32'(item_q.slot_id) < 32'(NUM_SLOTS);
	assign best_in = 32'(best_q) < 32'(NUM_SLOTS);

	always_comb begin
		case (cmd.ra_sel)
			tss_pkg::RA_SID:  raddr = sid_a;
			tss_pkg::RA_CUR:  raddr = cur_a;
			tss_pkg::RA_BEST: raddr = best_a;
			default:          raddr = idx_q;
		endcase
	end

	assign st_eff  = vbit_s1 ? tss_pkg::slot_st_t'(st_rdata) : tss_pkg::ST_FREE;
	assign sleep_t = (quot == 32'd0) ? 32'd1 : quot;
	assign run_ok  = best_in && (st_eff != tss_pkg::ST_FREE);
	assign better  = !found_q || (best_tk_q < tk_rdata) || (sp_rdata < best_sp_q);

	always_comb begin
		st_we = 1'b0;
		tk_we = 1'b0;
		sp_we = 1'b0;
		pr_we = 1'b0;
		waddr = idx_q;
		st_wd = tss_pkg::ST_FREE;
		tk_wd = '0;
		sp_wd = '0;
		case (cmd.wr)
			tss_pkg::WR_CREATE: begin
				st_we = 1'b1;
				st_wd = tss_pkg::ST_READY;
				pr_we = 1'b1;
				tk_we = 1'b1;
				tk_wd = 32'(item_q.prio_value);
				sp_we = 1'b1;
			end
			tss_pkg::WR_TARGET: begin
				waddr = sid_a;
				st_we = 1'b1;
				if (item_q.action == tss_pkg::ACT_BLOCK) begin
					st_wd = item_q.block_kind ? tss_pkg::ST_WAITING : tss_pkg::ST_BLOCKED;
				end else begin
					st_wd = tss_pkg::ST_READY;
				end
			end
			tss_pkg::WR_SLEEP: begin
				waddr = cur_a;
				st_we = 1'b1;
				st_wd = tss_pkg::ST_SLEEPING;
				tk_we = 1'b1;
				tk_wd = now_q + sleep_t;
			end
			tss_pkg::WR_RETIRE: begin
				waddr = cur_a;
				st_wd = tss_pkg::ST_READY;
				tk_wd = 32'(pr_rdata);
				if (cur_in && st_eff != tss_pkg::ST_FREE) begin
					st_we = st_eff == tss_pkg::ST_RUNNING;
					tk_we = tk_rdata == 32'd0;
				end
			end
			tss_pkg::WR_RUN: begin
				waddr = best_a;
				st_we = run_ok;
				st_wd = tss_pkg::ST_RUNNING;
			end
			tss_pkg::WR_ACCOUNT: begin
				waddr = sid_a;
				tk_we = 1'b1;
				tk_wd = item_q.slice_value;
				sp_we = 1'b1;
				sp_wd = item_q.stamp_value;
			end
			default: begin
			end
		endcase
		if (cmd.eval_tick && vld_s1 && st_eff == tss_pkg::ST_SLEEPING && tk_rdata <= now_q) begin
			waddr = idx_s1;
			st_we = 1'b1;
			st_wd = tss_pkg::ST_READY;
			tk_we = 1'b1;
			tk_wd = '0;
		end
	end

	tss_ram #(.WIDTH(3), .DEPTH(NUM_SLOTS)) u_st_ram (
		.clk(clk), .we(st_we), .waddr(waddr), .wdata(st_wd),
		.raddr(raddr), .rdata(st_rdata)
	);
	tss_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_tk_ram (
		.clk(clk), .we(tk_we), .waddr(waddr), .wdata(tk_wd),
		.raddr(raddr), .rdata(tk_rdata)
	);
	tss_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_sp_ram (
		.clk(clk), .we(sp_we), .waddr(waddr), .wdata(sp_wd),
		.raddr(raddr), .rdata(sp_rdata)
	);
	tss_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS)) u_pr_ram (
		.clk(clk), .we(pr_we), .waddr(waddr), .wdata(item_q.prio_value),
		.raddr(raddr), .rdata(pr_rdata)
	);

	tss_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(item_q.duration_ms), .divisor(tickms_q),
		.done(div_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q   <= tss_pkg::IDLE_SLOT_RST;
			tickms_q <= tss_pkg::TICK_MS_RST;
			now_q    <= '0;
			valid_q  <= '0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (tss_pkg::cfg_idx_t'(cfg_idx))
					tss_pkg::CFG_IDLE_SLOT: idle_q <= cfg_data[5:0];
					tss_pkg::CFG_TICK_MS:   tickms_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.now_inc) begin
				now_q <= now_q + 32'd1;
			end
			if (cmd.wr == tss_pkg::WR_CREATE) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			vld_s1 <= cmd.scan_rd;
			if (cmd.best_clr) begin
				found_q <= 1'b0;
			end else if (cmd.eval_sched && vld_s1 && st_eff == tss_pkg::ST_READY &&
					idx1_x != cur_x && better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		vbit_s1 <= valid_q[raddr];
		if (cmd.load) begin
			item_q <= req_item;
		end
		if (cmd.eval_sched && vld_s1 && st_eff == tss_pkg::ST_READY &&
				idx1_x != cur_x && better) begin
			best_q    <= idx1_x;
			best_tk_q <= tk_rdata;
			best_sp_q <= sp_rdata;
		end else if (cmd.best_resolve && !found_q) begin
			best_q <= XW'(idle_q);
		end
		if (cmd.load) begin
			res_q <= '0;
		end else begin
			if (cmd.set_st) begin
				res_q.status_code <= cmd.st_code;
			end
			if (cmd.wr == tss_pkg::WR_CREATE) begin
				res_q.new_slot <= idx_x[5:0];
			end
			if (cmd.wr == tss_pkg::WR_RUN) begin
				res_q.next_slot     <= best_q[5:0];
				res_q.rescheduled   <= 1'b1;
				res_q.switch_needed <= best_q != cur_x;
				if (!run_ok) begin
					res_q.status_code <= tss_pkg::STAT_ILLEGAL;
				end
			end
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		case (item_q.action)
			tss_pkg::ACT_BLOCK: legal = sid_in &&
				(st_eff == tss_pkg::ST_READY || st_eff == tss_pkg::ST_RUNNING);
			tss_pkg::ACT_UNBLOCK: legal = sid_in &&
				(st_eff == tss_pkg::ST_BLOCKED || st_eff == tss_pkg::ST_WAITING ||
				st_eff == tss_pkg::ST_SLEEPING);
			tss_pkg::ACT_SLEEP: legal = cur_in &&
				(st_eff == tss_pkg::ST_READY || st_eff == tss_pkg::ST_RUNNING);
			default: legal = 1'b0;
		endcase
	end

	assign stat.legal      = legal;
	assign stat.action     = item_q.action;
	assign stat.idx_last   = idx_q == LAST;
	assign stat.slot_free  = !valid_q[idx_q];
	assign stat.acct_legal = sid_in && valid_q[sid_a];
	assign stat.sid_is_cur = item_q.slot_id == item_q.current_slot;
	assign stat.div_done   = div_done;
	assign rsp_item        = out_q;

	a_slots_never_freed: assert property (@(posedge clk) disable iff (!arst_n)
		((~valid_q & $past(valid_q)) == '0))
		else $error("slot valid bit cleared");
	a_create_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr == tss_pkg::WR_CREATE) |-> !valid_q[idx_q])
		else $error("create into a live slot");
endmodule
`default_nettype wire

// ----- rtl/tss_ctrl.sv -----
// Sequencer of the task scheduler table: walks each item through scans, checks,
// divide and writes, and holds the response valid. Depends on tss_pkg.
`default_nettype none
module tss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tss_pkg::dp_cmd_t  cmd,
	input  tss_pkg::dp_stat_t stat
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_CR_SCAN,
		S_SC_SCAN,
		S_SC_DRAIN,
		S_SC_RESOLVE,
		S_SC_RETIRE,
		S_SC_RUNRD,
		S_SC_RUN,
		S_TGT_CHK,
		S_SL_CHK,
		S_SL_DIV,
		S_SL_WR,
		S_TK_SCAN,
		S_TK_DRAIN,
		S_FINISH
	} state_t;

	state_t st_q;
	state_t st_d;
	logic   rsp_valid_q;

	always_comb begin
		cmd  = '0;
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				cmd.load = req_valid;
				if (req_valid) begin
					st_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.action)
					tss_pkg::ACT_CREATE: begin
						cmd.idx_clr = 1'b1;
						st_d = S_CR_SCAN;
					end
					tss_pkg::ACT_SCHED: begin
						cmd.idx_clr  = 1'b1;
						cmd.best_clr = 1'b1;
						st_d = S_SC_SCAN;
					end
					tss_pkg::ACT_BLOCK, tss_pkg::ACT_UNBLOCK: begin
						cmd.ra_sel = tss_pkg::RA_SID;
						st_d = S_TGT_CHK;
					end
					tss_pkg::ACT_SLEEP: begin
						cmd.ra_sel = tss_pkg::RA_CUR;
						st_d = S_SL_CHK;
					end
					tss_pkg::ACT_TICK: begin
						cmd.now_inc = 1'b1;
						cmd.idx_clr = 1'b1;
						st_d = S_TK_SCAN;
					end
					tss_pkg::ACT_ACCOUNT: begin
						if (stat.acct_legal) begin
							cmd.wr = tss_pkg::WR_ACCOUNT;
						end else begin
							cmd.set_st  = 1'b1;
							cmd.st_code = tss_pkg::STAT_ILLEGAL;
						end
						st_d = S_FINISH;
					end
					default: st_d = S_FINISH;
				endcase
			end
			S_CR_SCAN: begin
				if (stat.slot_free) begin
					cmd.wr = tss_pkg::WR_CREATE;
					st_d = S_FINISH;
				end else if (stat.idx_last) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = tss_pkg::STAT_FULL;
					st_d = S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SC_SCAN: begin
				cmd.scan_rd    = 1'b1;
				cmd.eval_sched = 1'b1;
				if (stat.idx_last) begin
					st_d = S_SC_DRAIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SC_DRAIN: begin
				cmd.eval_sched = 1'b1;
				st_d = S_SC_RESOLVE;
			end
			S_SC_RESOLVE: begin
				cmd.best_resolve = 1'b1;
				cmd.ra_sel = tss_pkg::RA_CUR;
				st_d = S_SC_RETIRE;
			end
			S_SC_RETIRE: begin
				cmd.wr = tss_pkg::WR_RETIRE;
				st_d = S_SC_RUNRD;
			end
			S_SC_RUNRD: begin
				cmd.ra_sel = tss_pkg::RA_BEST;
				st_d = S_SC_RUN;
			end
			S_SC_RUN: begin
				cmd.wr = tss_pkg::WR_RUN;
				st_d = S_FINISH;
			end
			S_TGT_CHK: begin
				if (stat.legal) begin
					cmd.wr = tss_pkg::WR_TARGET;
					if (stat.action == tss_pkg::ACT_BLOCK && stat.sid_is_cur) begin
						cmd.idx_clr  = 1'b1;
						cmd.best_clr = 1'b1;
						st_d = S_SC_SCAN;
					end else begin
						st_d = S_FINISH;
					end
				end else begin
					cmd.set_st  = 1'b1;
					cmd.st_code = tss_pkg::STAT_ILLEGAL;
					st_d = S_FINISH;
				end
			end
			S_SL_CHK: begin
				if (stat.legal) begin
					cmd.div_start = 1'b1;
					st_d = S_SL_DIV;
				end else begin
					cmd.set_st  = 1'b1;
					cmd.st_code = tss_pkg::STAT_ILLEGAL;
					st_d = S_FINISH;
				end
			end
			S_SL_DIV: begin
				if (stat.div_done) begin
					st_d = S_SL_WR;
				end
			end
			S_SL_WR: begin
				cmd.wr       = tss_pkg::WR_SLEEP;
				cmd.idx_clr  = 1'b1;
				cmd.best_clr = 1'b1;
				st_d = S_SC_SCAN;
			end
			S_TK_SCAN: begin
				cmd.scan_rd   = 1'b1;
				cmd.eval_tick = 1'b1;
				if (stat.idx_last) begin
					st_d = S_TK_DRAIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_TK_DRAIN: begin
				cmd.eval_tick = 1'b1;
				st_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.out_load = !rsp_valid_q || rsp_ready;
				if (!rsp_valid_q || rsp_ready) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = st_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && req_valid) |=> (st_q == S_DISPATCH))
		else $error("accepted beat did not start work");
	a_finish_posts_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FINISH && (!rsp_valid_q || rsp_ready)) |=> (rsp_valid_q && st_q == S_IDLE))
		else $error("finished item not posted");
endmodule
`default_nettype wire

// ----- bench/tss_tb_pkg.sv -----
`timescale 1ns / 100ps
// Typed item and result records for the task scheduler table bench.
// Depends on tss_pkg.
package tss_tb_pkg;
	import tss_pkg::*;

	typedef struct {
		act_t        action;
		logic [5:0]  slot_id;
		logic [5:0]  current_slot;
		logic        block_kind;
		logic [7:0]  prio_value;
		logic [31:0] duration_ms;
		logic [31:0] slice_value;
		logic [31:0] stamp_value;
	} sched_item_t;

	typedef struct {
		logic [5:0] next_slot;
		logic       rescheduled;
		logic       switch_needed;
		logic [5:0] new_slot;
		logic [1:0] status_code;
	} sched_result_t;
endpackage

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Bench for task_scheduler_table_top: directed and random items, predicted slot table,
// per-field checks of every result beat. Depends on tss_pkg, tss_tb_pkg and both channel interfaces.
module testbench;
	import tss_pkg::*;
	import tss_tb_pkg::*;

	localparam int NSLOT = 64;
	localparam int LIMIT_CYCLES = 1500000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [0:0] cfg_idx;
	logic [9:0] cfg_data;

	tss_req_if req ();
	tss_rsp_if rsp ();

	task_scheduler_table_top i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	slot_st_t    tbl_state [NSLOT];
	logic [31:0] tbl_ticks [NSLOT];
	logic [31:0] tbl_stamp [NSLOT];
	logic [7:0]  tbl_prio  [NSLOT];
	logic [31:0] clock_ticks;
	logic [5:0]  idle_choice;
	logic [9:0]  ms_per_tick;

	sched_result_t pending_results[$];
	int  errors;
	int  cycles;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic bit is_live(logic [5:0] s);
		return tbl_state[s] != ST_FREE;
	endfunction

	function automatic void pick_next(logic [5:0] cur, ref sched_result_t r);
		int  best;
		bit  found;
		best = 0;
		found = 0;
		for (int i = 0; i < NSLOT; i++) begin
			if (tbl_state[i] != ST_READY || i == int'(cur)) continue;
			if (!found || tbl_ticks[best] < tbl_ticks[i] || tbl_stamp[i] < tbl_stamp[best]) begin
				best = i;
				found = 1;
			end
		end
		if (!found) best = int'(idle_choice);
		if (is_live(cur)) begin
			if (tbl_state[cur] == ST_RUNNING) tbl_state[cur] = ST_READY;
			if (tbl_ticks[cur] == 0) tbl_ticks[cur] = {24'd0, tbl_prio[cur]};
		end
		if (is_live(best[5:0])) tbl_state[best] = ST_RUNNING;
		else r.status_code = STAT_ILLEGAL;
		r.next_slot = best[5:0];
		r.rescheduled = 1'b1;
		r.switch_needed = (best[5:0] != cur);
	endfunction

	function automatic sched_result_t predict_result(sched_item_t it);
		sched_result_t r;
		logic [31:0]   len;
		logic [31:0]   t;
		logic [5:0]    sid;
		logic [5:0]    cur;
		r = '{default: '0};
		sid = it.slot_id;
		cur = it.current_slot;
		case (it.action)
			ACT_CREATE: begin
				r.status_code = STAT_FULL;
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_state[i] == ST_FREE) begin
						tbl_state[i] = ST_READY;
						tbl_prio[i] = it.prio_value;
						tbl_ticks[i] = {24'd0, it.prio_value};
						tbl_stamp[i] = '0;
						r.new_slot = i[5:0];
						r.status_code = STAT_OK;
						break;
					end
				end
			end
			ACT_SCHED: pick_next(cur, r);
			ACT_BLOCK: begin
				if (tbl_state[sid] == ST_READY || tbl_state[sid] == ST_RUNNING) begin
					tbl_state[sid] = it.block_kind ? ST_WAITING : ST_BLOCKED;
					if (sid == cur) pick_next(cur, r);
				end else r.status_code = STAT_ILLEGAL;
			end
			ACT_UNBLOCK: begin
				if (tbl_state[sid] == ST_BLOCKED || tbl_state[sid] == ST_WAITING ||
						tbl_state[sid] == ST_SLEEPING) tbl_state[sid] = ST_READY;
				else r.status_code = STAT_ILLEGAL;
			end
			ACT_SLEEP: begin
				if (tbl_state[cur] == ST_READY || tbl_state[cur] == ST_RUNNING) begin
					len = (ms_per_tick == 0) ? 32'd1 : {22'd0, ms_per_tick};
					t = it.duration_ms / len;
					if (t == 0) t = 1;
					tbl_ticks[cur] = clock_ticks + t;
					tbl_state[cur] = ST_SLEEPING;
					pick_next(cur, r);
				end else r.status_code = STAT_ILLEGAL;
			end
			ACT_TICK: begin
				clock_ticks = clock_ticks + 32'd1;
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_state[i] == ST_SLEEPING && tbl_ticks[i] <= clock_ticks) begin
						tbl_ticks[i] = '0;
						tbl_state[i] = ST_READY;
					end
				end
			end
			ACT_ACCOUNT: begin
				if (is_live(sid)) begin
					tbl_ticks[sid] = it.slice_value;
					tbl_stamp[sid] = it.stamp_value;
				end else r.status_code = STAT_ILLEGAL;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(sched_item_t it);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		req.valid        <= 1'b1;
		req.action       <= it.action;
		req.slot_id      <= it.slot_id;
		req.current_slot <= it.current_slot;
		req.block_kind   <= it.block_kind;
		req.prio_value   <= it.prio_value;
		req.duration_ms  <= it.duration_ms;
		req.slice_value  <= it.slice_value;
		req.stamp_value  <= it.stamp_value;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_results.push_back(predict_result(it));
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		sched_result_t e;
		if (rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, got slot %0d status %0d",
					$time, rsp.next_slot, rsp.status_code);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (e.next_slot !== rsp.next_slot) begin
					$display("%0t: next_slot exp %0d got %0d", $time, e.next_slot, rsp.next_slot);
					errors++;
				end
				if (e.rescheduled !== rsp.rescheduled) begin
					$display("%0t: rescheduled exp %0d got %0d", $time, e.rescheduled,
						rsp.rescheduled);
					errors++;
				end
				if (e.switch_needed !== rsp.switch_needed) begin
					$display("%0t: switch_needed exp %0d got %0d", $time, e.switch_needed,
						rsp.switch_needed);
					errors++;
				end
				if (e.new_slot !== rsp.new_slot) begin
					$display("%0t: new_slot exp %0d got %0d", $time, e.new_slot, rsp.new_slot);
					errors++;
				end
				if (e.status_code !== rsp.status_code) begin
					$display("%0t: status_code exp %0d got %0d", $time, e.status_code,
						rsp.status_code);
					errors++;
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic drain;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [9:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDLE_SLOT) idle_choice = val[5:0];
		else ms_per_tick = val;
		@(posedge clk);
	endtask

	function automatic sched_item_t rand_item();
		sched_item_t it;
		int          k;
		it.action       = act_t'($urandom_range(7));
		it.slot_id      = 6'($urandom_range(63));
		it.current_slot = 6'($urandom_range(63));
		it.block_kind   = 1'($urandom_range(1));
		it.prio_value   = 8'($urandom_range(255, 1));
		k = $urandom_range(3);
		it.duration_ms  = (k == 0) ? $urandom() : $urandom_range(3000);
		it.slice_value  = (k == 1) ? $urandom() : $urandom_range(300);
		it.stamp_value  = (k == 2) ? $urandom() : $urandom_range(300);
		return it;
	endfunction

	function automatic sched_item_t make_item(act_t a, logic [5:0] sid, logic [5:0] cur);
		sched_item_t it;
		it = rand_item();
		it.action = a;
		it.slot_id = sid;
		it.current_slot = cur;
		return it;
	endfunction

	// pick targets mostly among live slots
	function automatic logic [5:0] live_pick();
		logic [5:0] s;
		for (int n = 0; n < 8; n++) begin
			s = 6'($urandom_range(63));
			if (is_live(s)) return s;
		end
		return s;
	endfunction

	task automatic test_directed;
		sched_item_t it;
		send_item(make_item(ACT_SCHED, 6'd0, 6'd0));
		send_item(make_item(ACT_SLEEP, 6'd0, 6'd63));
		send_item(make_item(ACT_ACCOUNT, 6'd63, 6'd0));
		send_item(make_item(ACT_UNBLOCK, 6'd5, 6'd0));
		send_item(make_item(ACT_BLOCK, 6'd5, 6'd0));
		it = make_item(ACT_CREATE, 6'd0, 6'd0);
		it.prio_value = 8'd255;
		send_item(it);
		it.prio_value = 8'd1;
		send_item(it);
		send_item(make_item(ACT_SCHED, 6'd0, 6'd0));
		it = make_item(ACT_ACCOUNT, 6'd1, 6'd0);
		it.slice_value = 32'hFFFF_FFFF;
		it.stamp_value = 32'hFFFF_FFFF;
		send_item(it);
		it = make_item(ACT_SLEEP, 6'd0, 6'd0);
		it.duration_ms = 32'hFFFF_FFFF;
		send_item(it);
		it = make_item(ACT_SLEEP, 6'd0, 6'd1);
		it.duration_ms = 32'd0;
		send_item(it);
		send_item(make_item(ACT_TICK, 6'd0, 6'd0));
		send_item(make_item(ACT_UNBLOCK, 6'd0, 6'd0));
		it = make_item(ACT_BLOCK, 6'd1, 6'd1);
		it.block_kind = 1'b1;
		send_item(it);
		send_item(make_item(ACT_UNBLOCK, 6'd1, 6'd0));
		it = make_item(ACT_BLOCK, 6'd0, 6'd3);
		it.block_kind = 1'b0;
		send_item(it);
		send_item(make_item(act_t'(3'd7), 6'd63, 6'd63));
		drain();
	endtask

	task automatic test_full_table;
		for (int i = 0; i < NSLOT + 2; i++) send_item(make_item(ACT_CREATE, 6'd0, 6'd0));
		drain();
	endtask

	task automatic test_random(int count);
		sched_item_t it;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) < 8) begin
				it = rand_item();
				if (it.action == act_t'(3'd7)) it.action = ACT_TICK;
				it.slot_id = live_pick();
				it.current_slot = ($urandom_range(3) == 0) ? live_pick() : it.current_slot;
				if (it.action == ACT_SLEEP) it.current_slot = live_pick();
				if (it.action == ACT_SLEEP && $urandom_range(1)) it.duration_ms = $urandom_range(60);
			end else it = rand_item();
			send_item(it);
		end
	endtask

	task automatic test_backpressure;
		hold_cycles <= 3000;
		for (int n = 0; n < 30; n++) send_item(make_item(ACT_ACCOUNT, live_pick(), 6'd0));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.action = '0;
		req.slot_id = '0;
		req.current_slot = '0;
		req.block_kind = 1'b0;
		req.prio_value = '0;
		req.duration_ms = '0;
		req.slice_value = '0;
		req.stamp_value = '0;
		rsp.ready = 1'b0;
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		send_idle_pct = 10;
		recv_idle_pct = 64;
		for (int i = 0; i < NSLOT; i++) begin
			tbl_state[i] = ST_FREE;
			tbl_ticks[i] = '0;
			tbl_stamp[i] = '0;
			tbl_prio[i] = '0;
		end
		clock_ticks = '0;
		idle_choice = IDLE_SLOT_RST;
		ms_per_tick = TICK_MS_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_reg(CFG_IDLE_SLOT, 10'd63);
		write_reg(CFG_TICK_MS, 10'd1);
		test_full_table();
		test_random(450);
		drain();

		send_idle_pct = 64;
		recv_idle_pct = 10;
		write_reg(CFG_IDLE_SLOT, 10'd2);
		write_reg(CFG_TICK_MS, 10'd1000);
		test_backpressure();
		test_random(450);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_TICK_MS, 10'd0);
		write_reg(CFG_IDLE_SLOT, 10'd0);
		test_random(450);
		drain();

		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
